// ===== rtl/core/crs_pkg.sv =====
// Shared types and constants for the RGB contrast stretch block.
`timescale 1ns / 1ps
`default_nettype none
package crs_pkg;

	localparam int NUM_CH    = 3;
	localparam int CH_W      = 8;
	localparam int NUM_W     = 2 * CH_W;
	localparam int DIV_STEPS = CH_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;
	localparam logic [CH_W-1:0] LOW_RESET  = 8'd255;
	localparam logic [CH_W-1:0] HIGH_RESET = 8'd0;

	localparam logic MODE_MEASURE = 1'b0;
	localparam logic MODE_APPLY   = 1'b1;

	typedef logic [NUM_CH-1:0][CH_W-1:0]  pix_t;
	typedef logic [NUM_CH-1:0][NUM_W-1:0] num_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/crs_track.sv =====
// Running per-channel minimum and maximum of measure-pass pixels.
`timescale 1ns / 1ps
`default_nettype none
module crs_track
	import crs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic upd,
	input  wire logic restart,
	input  wire pix_t pix,
	output pix_t      lo,
	output pix_t      hi
);

	pix_t lo_q;
	pix_t hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				lo_q[c] <= LOW_RESET;
				hi_q[c] <= HIGH_RESET;
			end
		end else if (upd) begin
			for (int c = 0; c < NUM_CH; c++) begin
				if (restart) begin
					lo_q[c] <= pix[c];
					hi_q[c] <= pix[c];
				end else begin
					if (pix[c] < lo_q[c]) lo_q[c] <= pix[c];
					if (pix[c] > hi_q[c]) hi_q[c] <= pix[c];
				end
			end
		end
	end

	assign lo = lo_q;
	assign hi = hi_q;

	a_restart_flat: assert property (@(posedge clk) disable iff (!arst_n)
		upd && restart |=> lo_q == hi_q && lo_q == $past(pix))
		else $error("restart did not load low and high from the pixel");

	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> lo_q[0] <= hi_q[0] && lo_q[1] <= hi_q[1] && lo_q[2] <= hi_q[2])
		else $error("low above high after a measure beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(lo_q) && $stable(hi_q))
		else $error("range changed without a measure beat");

endmodule
`default_nettype wire

// ===== rtl/core/crs_div.sv =====
// Three-lane restoring divider, one quotient bit per lane per cycle.
`timescale 1ns / 1ps
`default_nettype none
module crs_div
	import crs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_ctl_t ctl,
	input  wire num_t     num,
	input  wire pix_t     span,
	output div_stat_t     st,
	output pix_t          quo
);

	pix_t             rem_q;
	pix_t             sh_q;
	pix_t             span_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [NUM_CH-1:0][CH_W+1:0] trial;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			trial[c] = {1'b0, rem_q[c], sh_q[c][CH_W-1]} - {2'b00, span_q[c]};
		end
	end

	// remainder starts at the upper half of the numerator: it is below the span
	// because the quotient fits in eight bits
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int c = 0; c < NUM_CH; c++) begin
				rem_q[c]  <= num[c][NUM_W-1:CH_W];
				sh_q[c]   <= num[c][CH_W-1:0];
				span_q[c] <= span[c];
			end
		end else if (busy_q) begin
			for (int c = 0; c < NUM_CH; c++) begin
				if (!trial[c][CH_W+1]) begin
					rem_q[c] <= trial[c][CH_W-1:0];
					sh_q[c]  <= {sh_q[c][CH_W-2:0], 1'b1};
				end else begin
					rem_q[c] <= {rem_q[c][CH_W-2:0], sh_q[c][CH_W-1]};
					sh_q[c]  <= {sh_q[c][CH_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.load) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign quo     = sh_q;

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> busy_q && cnt_q == '0)
		else $error("divider did not start on load");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("done without a finished run");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q < CNT_W'(DIV_STEPS))
		else $error("step count out of range");

endmodule
`default_nettype wire

// ===== rtl/core/rgb_contrast_stretch_top.sv =====
// Top level of the RGB contrast stretch: sequencer, operand setup and output register.
//
//  channel  | dir | tdata (low bit up)          | tuser (low bit up)
//  s_axis   | in  | red_in, green_in, blue_in   | mode, first_of_frame
//  m_axis   | out | red_out, green_out, blue_out| -
//
// Measure beats update the running range; no output beat.
// Apply beats go through capture, operand setup, 8 divider steps, the registered
// done flag and output load; the shared three-lane divider gives one
// quotient bit per lane per cycle.
// Reset clears the range to low 255 / high 0 and empties the output register.
// Output stalls hold only the final load; s_axis_tready is low while an apply beat runs.
`timescale 1ns / 1ps
`default_nettype none
module rgb_contrast_stretch_top
	import crs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
	input  wire logic [1:0]  s_axis_tuser,  // mode, first_of_frame
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata   // red_out, green_out, blue_out
);

	state_t state_q;
	state_t state_nxt;

	pix_t              pix_in;
	pix_t              pix_q;
	pix_t              lo;
	pix_t              hi;
	pix_t              quo;
	pix_t              span;
	num_t              num;
	logic [NUM_CH-1:0] zero_q;
	logic [NUM_CH-1:0] full_q;
	pix_t              out_q;
	logic              out_vld_q;

	logic      acc;
	logic      upd;
	logic      out_load;
	div_ctl_t  dctl;
	div_stat_t dst;

	assign pix_in[0] = s_axis_tdata[7:0];
	assign pix_in[1] = s_axis_tdata[15:8];
	assign pix_in[2] = s_axis_tdata[23:16];

	assign acc = s_axis_tvalid && s_axis_tready;
	assign upd = acc && s_axis_tuser[0] == MODE_MEASURE;

	crs_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd),
		.restart (s_axis_tuser[1]),
		.pix     (pix_in),
		.lo      (lo),
		.hi      (hi)
	);

	// numerator (v - lo) * 255 as (d << 8) - d
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			span[c] = hi[c] - lo[c];
			num[c]  = {pix_q[c] - lo[c], {CH_W{1'b0}}} - {{CH_W{1'b0}}, pix_q[c] - lo[c]};
		end
	end

	crs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dctl),
		.num    (num),
		.span   (span),
		.st     (dst),
		.quo    (quo)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (acc && s_axis_tuser[0] == MODE_APPLY) state_nxt = ST_PREP;
			ST_PREP: state_nxt = ST_DIV;
			ST_DIV:  if (dst.done) state_nxt = ST_DONE;
			ST_DONE: if (!out_vld_q || m_axis_tready) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		dctl.load     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_PREP: dctl.load = 1'b1;
			ST_DIV:  ;
			ST_DONE: out_load = !out_vld_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) pix_q <= pix_in;
		if (state_q == ST_PREP) begin
			for (int c = 0; c < NUM_CH; c++) begin
				zero_q[c] <= hi[c] <= lo[c] || pix_q[c] <= lo[c];
				full_q[c] <= pix_q[c] >= hi[c];
			end
		end
		if (out_load) begin
			for (int c = 0; c < NUM_CH; c++) begin
				if (zero_q[c])      out_q[c] <= '0;
				else if (full_q[c]) out_q[c] <= FULL_SCALE;
				else                out_q[c] <= quo[c];
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_q[2], out_q[1], out_q[0]};

	a_apply_starts: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_axis_tuser[0] == MODE_APPLY |=> state_q == ST_PREP ##1 dst.busy)
		else $error("apply beat did not start the divider");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dst.busy |-> !s_axis_tready)
		else $error("input accepted while dividing");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid)
		else $error("output load lost");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_vld_q || m_axis_tready)
		else $error("pending output overwritten");

endmodule
`default_nettype wire

// ===== sim/rgb_contrast_stretch_top_test.sv =====
// Self-checking testbench for the RGB contrast stretch top level.
`timescale 1ns / 1ps
module rgb_contrast_stretch_top_test;
	import crs_pkg::*;

	localparam int TOTAL_PIXELS    = 900;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_CYCLES = 3000;
	localparam int DRAIN_CYCLES    = 30;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // red_in, green_in, blue_in
	logic [1:0]  s_axis_tuser;   // mode, first_of_frame
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // red_out, green_out, blue_out

	// running range as the block should hold it; index 0 is red
	pix_t range_lo;
	pix_t range_hi;
	pix_t stretched_q[$];

	int   mismatch_count;
	int   pixels_sent;
	logic idle_en;
	logic hold_req;
	int   hold_left;
	int   stall_left;
	int   idle_cycles;
	string chan_name[NUM_CH] = '{"red", "green", "blue"};

	rgb_contrast_stretch_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [CH_W-1:0] stretch_channel(input logic [CH_W-1:0] v,
			input logic [CH_W-1:0] lo, input logic [CH_W-1:0] hi);
		int span;
		int num;
		logic [CH_W-1:0] q;
		if (hi <= lo) return '0;
		if (v <= lo) return '0;
		if (v >= hi) return FULL_SCALE;
		span = int'(hi) - int'(lo);
		num  = (int'(v) - int'(lo)) * int'(FULL_SCALE);
		q    = CH_W'(num / span);
		return q;
	endfunction

	function automatic logic [CH_W-1:0] clamp_chan(input int v);
		if (v < 0) return '0;
		if (v > 255) return 8'd255;
		return CH_W'(v);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_length();
		if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// update the range or queue the stretched pixel for one accepted beat
	task automatic predict_pixel(input logic mode, input logic first, input pix_t px);
		pix_t res;
		for (int c = 0; c < NUM_CH; c++) begin
			if (mode == MODE_MEASURE) begin
				if (first) begin
					range_lo[c] = px[c];
					range_hi[c] = px[c];
				end else begin
					if (px[c] < range_lo[c]) range_lo[c] = px[c];
					if (px[c] > range_hi[c]) range_hi[c] = px[c];
				end
			end else begin
				res[c] = stretch_channel(px[c], range_lo[c], range_hi[c]);
			end
		end
		if (mode == MODE_APPLY) stretched_q.push_back(res);
	endtask

	task automatic send_pixel(input logic mode, input logic first, input pix_t px);
		int gap;
		gap = (idle_en && $urandom_range(0, 99) < 35) ? gap_length() : 0;
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = px;
		s_axis_tuser  = {first, mode};
		do @(posedge clk); while (!s_axis_tready);
		predict_pixel(mode, first, px);
		pixels_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (stretched_q.size() != 0) @(posedge clk);
	endtask

	function automatic pix_t rgb(input int r, input int g, input int b);
		pix_t px;
		px[0] = CH_W'(r);
		px[1] = CH_W'(g);
		px[2] = CH_W'(b);
		return px;
	endfunction

	// apply beats before any measure beat: every channel reads as unmeasured
	task automatic test_unmeasured();
		idle_en = 1'b0;
		send_pixel(MODE_APPLY, 1'b1, rgb(0, 0, 0));
		send_pixel(MODE_APPLY, 1'b0, rgb(255, 255, 255));
		send_pixel(MODE_APPLY, 1'b0, rgb(128, 1, 254));
	endtask

	task automatic test_range_cases();
		idle_en = 1'b1;
		// widening from the reset range collapses it onto the pixel
		send_pixel(MODE_MEASURE, 1'b0, rgb(40, 0, 255));
		send_pixel(MODE_APPLY, 1'b0, rgb(40, 0, 255));
		send_pixel(MODE_APPLY, 1'b0, rgb(0, 255, 0));
		// restart, then red 100..200, green 0..255, blue flat at 7
		send_pixel(MODE_MEASURE, 1'b1, rgb(100, 0, 7));
		send_pixel(MODE_MEASURE, 1'b0, rgb(200, 255, 7));
		send_pixel(MODE_MEASURE, 1'b0, rgb(150, 128, 7));
		send_pixel(MODE_APPLY, 1'b0, rgb(99, 0, 7));
		send_pixel(MODE_APPLY, 1'b0, rgb(100, 255, 200));
		send_pixel(MODE_APPLY, 1'b0, rgb(200, 1, 0));
		send_pixel(MODE_APPLY, 1'b0, rgb(201, 254, 255));
		send_pixel(MODE_APPLY, 1'b0, rgb(150, 127, 7));
		// frame mark on an apply beat has no effect
		send_pixel(MODE_APPLY, 1'b1, rgb(123, 77, 33));
		send_pixel(MODE_APPLY, 1'b0, rgb(123, 77, 33));
		send_pixel(MODE_MEASURE, 1'b1, rgb(0, 0, 0));
		send_pixel(MODE_MEASURE, 1'b0, rgb(255, 255, 255));
		send_pixel(MODE_APPLY, 1'b0, rgb(0, 255, 170));
		// span of one
		send_pixel(MODE_MEASURE, 1'b1, rgb(9, 9, 9));
		send_pixel(MODE_MEASURE, 1'b0, rgb(10, 10, 10));
		send_pixel(MODE_APPLY, 1'b0, rgb(9, 10, 11));
	endtask

	// receiver holds off long enough for the input side to back up
	task automatic test_output_hold();
		idle_en = 1'b0;
		send_pixel(MODE_MEASURE, 1'b1, rgb(20, 60, 100));
		send_pixel(MODE_MEASURE, 1'b0, rgb(220, 180, 140));
		hold_req = 1'b1;
		repeat (12) send_pixel(MODE_APPLY, 1'b0, pix_t'($urandom));
	endtask

	task automatic test_drain_pause();
		idle_en = 1'b1;
		repeat (4) send_pixel(MODE_APPLY, 1'b0, pix_t'($urandom));
		wait_drained();
		send_pixel(MODE_MEASURE, 1'b1, pix_t'($urandom));
		repeat (4) send_pixel(MODE_APPLY, 1'b0, pix_t'($urandom));
	endtask

	task automatic test_random_frames();
		int kind;
		int n_meas;
		int n_apply;
		int ctr[NUM_CH];
		int wid[NUM_CH];
		pix_t px;
		while (pixels_sent < TOTAL_PIXELS) begin
			idle_en = ($urandom_range(0, 4) != 0);
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				// noise: any mode, any frame mark
				repeat ($urandom_range(1, 12))
					send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						pix_t'($urandom));
			end else begin
				for (int c = 0; c < NUM_CH; c++) begin
					ctr[c] = $urandom_range(0, 255);
					case ($urandom_range(0, 3))
						0: wid[c] = 0;
						1: wid[c] = $urandom_range(1, 8);
						2: wid[c] = $urandom_range(9, 80);
						default: wid[c] = 255;
					endcase
				end
				n_meas = $urandom_range(1, 16);
				for (int i = 0; i < n_meas; i++) begin
					for (int c = 0; c < NUM_CH; c++)
						px[c] = clamp_chan(ctr[c] - wid[c] / 2 + int'($urandom_range(0, wid[c])));
					// kind 1 leaves out the restart so the old range carries over
					send_pixel(MODE_MEASURE, (i == 0) && (kind != 1), px);
				end
				n_apply = $urandom_range(1, 24);
				for (int i = 0; i < n_apply; i++) begin
					for (int c = 0; c < NUM_CH; c++)
						px[c] = clamp_chan(ctr[c] - wid[c] / 2 - 8
							+ int'($urandom_range(0, wid[c] + 16)));
					send_pixel(MODE_APPLY, 1'($urandom_range(0, 1)), px);
				end
			end
		end
	endtask

	// output side: drive tready, check every beat against the oldest expectation
	initial begin
		pix_t want;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (stretched_q.size() == 0) begin
					report_mismatch($sformatf("unexpected output beat %h", m_axis_tdata));
				end else begin
					want = stretched_q.pop_front();
					for (int c = 0; c < NUM_CH; c++)
						if (m_axis_tdata[c*CH_W +: CH_W] !== want[c])
							report_mismatch($sformatf("%s_out expected %0d got %0d",
								chan_name[c], want[c], m_axis_tdata[c*CH_W +: CH_W]));
				end
			end
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
				if (idle_en && $urandom_range(0, 99) < 25) stall_left = gap_length();
			end
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("[rgb_contrast_stretch_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		range_lo       = {NUM_CH{LOW_RESET}};
		range_hi       = {NUM_CH{HIGH_RESET}};
		mismatch_count = 0;
		pixels_sent    = 0;
		idle_en        = 1'b0;
		hold_req       = 1'b0;
		hold_left      = 0;
		stall_left     = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_unmeasured();
		test_range_cases();
		test_output_hold();
		test_drain_pause();
		test_random_frames();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[rgb_contrast_stretch_top] OK");
		else
			$display("[rgb_contrast_stretch_top] ERROR");
		$finish;
	end

endmodule
